// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int OP_W          = 2;
    localparam int DELAY_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ID_OUT_W      = 3;
    localparam int CNT_OUT_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_CREATE    = 2'd1,
        OP_SET_DELAY = 2'd2,
        OP_STATUS    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_ROT,
        S_ROT_DONE,
        S_FIN_RD,
        S_OUT
    } t_state;

    // requests from the scheduler control to the ready queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

// ===== rtl/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with per-task delay counters and a round-robin ready queue.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low, and exactly one
// result word follows, shown for a single cycle with o_valid; the receiver
// cannot stall it. Every command passes through S_EXEC, S_FIN_RD and S_OUT
// before busy drops; a tick with tasks goes from S_EXEC through S_WALK,
// S_ROT and S_ROT_DONE first: the delay counters sit in one memory and the
// tick walks the created ones one per cycle through its read and write
// ports, then rotates the ready queue and reads back the running task's
// counter.
`default_nettype none

module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [DELAY_W-1:0]   i_delay_value,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic                      o_running_valid,
    output logic [ID_OUT_W-1:0]       o_running_id,
    output logic [DELAY_W-1:0]        o_running_delay,
    output logic [ID_OUT_W-1:0]       o_assigned_id,
    output logic [CNT_OUT_W-1:0]      o_task_count
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = CW + 1;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [DELAY_W-1:0]   r_dv, n_dv;
    logic                 r_running, n_running;
    logic [IW-1:0]        r_current, n_current;
    logic [CW-1:0]        r_created, n_created;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_wb_vld, n_wb_vld;
    logic [IW-1:0]        r_wb_idx, n_wb_idx;
    logic                 r_rot_pend, n_rot_pend;
    t_status              r_status, n_status;
    logic [IW-1:0]        r_assigned, n_assigned;

    // delay counter memory
    logic [DELAY_W-1:0]   d_mem [MAX_TASKS];
    logic [DELAY_W-1:0]   r_dly_rd;
    logic                 d_we;
    logic [IW-1:0]        d_waddr;
    logic [DELAY_W-1:0]   d_wdata;
    logic                 d_re;
    logic [IW-1:0]        d_raddr;

    t_q_ctrl              q_ctrl;
    logic [IW-1:0]        q_push_id;
    logic [IW-1:0]        q_pop_id;
    logic [CW-1:0]        q_fill;

    rrts_ready_queue #(
        .MAX_TASKS (MAX_TASKS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_push_id (q_push_id),
        .o_pop_id  (q_pop_id),
        .o_fill    (q_fill)
    );

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_dv       = r_dv;
        n_running  = r_running;
        n_current  = r_current;
        n_created  = r_created;
        n_idx      = r_idx;
        n_wb_vld   = r_wb_vld;
        n_wb_idx   = r_wb_idx;
        n_rot_pend = r_rot_pend;
        n_status   = r_status;
        n_assigned = r_assigned;
        d_we       = 1'b0;
        d_waddr    = r_current;
        d_wdata    = '0;
        d_re       = 1'b0;
        d_raddr    = r_current;
        q_ctrl     = '0;
        q_push_id  = r_current;
        o_valid    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_dv    = i_delay_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status   = ST_OK;
                n_assigned = '0;
                n_state    = S_FIN_RD;
                case (r_op)
                    OP_CREATE: begin
                        if (r_created >= CW'(MAX_TASKS)) begin
                            n_status = ST_FULL;
                        end else begin
                            d_we        = 1'b1;
                            d_waddr     = r_created[IW-1:0];
                            d_wdata     = '0;
                            q_ctrl.push = 1'b1;
                            q_push_id   = r_created[IW-1:0];
                            n_assigned  = r_created[IW-1:0];
                            n_created   = r_created + CW'(1);
                        end
                    end
                    OP_TICK: begin
                        if (r_created == '0) begin
                            n_status = ST_NONE;
                        end else begin
                            n_idx    = '0;
                            n_wb_vld = 1'b0;
                            n_state  = S_WALK;
                        end
                    end
                    OP_SET_DELAY: begin
                        if (!r_running) begin
                            n_status = ST_NONE;
                        end else begin
                            d_we    = 1'b1;
                            d_waddr = r_current;
                            d_wdata = r_dv;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                // read entry idx while writing back the entry read in the previous cycle
                if (r_wb_vld) begin
                    d_we    = 1'b1;
                    d_waddr = r_wb_idx;
                    d_wdata = (r_dly_rd != '0) ? (r_dly_rd - DELAY_W'(1)) : '0;
                end
                if (r_idx < r_created) begin
                    d_re     = 1'b1;
                    d_raddr  = r_idx[IW-1:0];
                    n_wb_vld = 1'b1;
                    n_wb_idx = r_idx[IW-1:0];
                    n_idx    = r_idx + CW'(1);
                end else begin
                    n_wb_vld = 1'b0;
                    // leave only once the last write-back has landed
                    if (!r_wb_vld) begin
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT: begin
                n_rot_pend = (q_fill != '0);
                if (q_fill != '0) begin
                    q_ctrl.pop  = 1'b1;
                    q_ctrl.push = r_running;
                    q_push_id   = r_current;
                end
                n_state = S_ROT_DONE;
            end
            S_ROT_DONE: begin
                if (r_rot_pend) begin
                    n_current = q_pop_id;
                    n_running = 1'b1;
                end
                n_state = S_FIN_RD;
            end
            S_FIN_RD: begin
                d_re    = 1'b1;
                d_raddr = r_current;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= 1'b0;
            r_current  <= '0;
            r_created  <= '0;
            r_wb_vld   <= 1'b0;
            r_rot_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_running  <= n_running;
            r_current  <= n_current;
            r_created  <= n_created;
            r_wb_vld   <= n_wb_vld;
            r_rot_pend <= n_rot_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_dv       <= n_dv;
        r_idx      <= n_idx;
        r_wb_idx   <= n_wb_idx;
        r_status   <= n_status;
        r_assigned <= n_assigned;
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            d_mem[d_waddr] <= d_wdata;
        end
        if (d_re) begin
            r_dly_rd <= d_mem[d_raddr];
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_status        = r_status;
    assign o_running_valid = r_running;
    assign o_running_id    = r_running ? ID_OUT_W'(r_current) : '0;
    assign o_running_delay = r_running ? r_dly_rd : '0;
    assign o_assigned_id   = ID_OUT_W'(r_assigned);
    assign o_task_count    = CNT_OUT_W'(r_created);

`ifndef SYNTHESIS
    // every created task is either running or waiting in the queue
    a_task_accounting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (SW'(q_fill) + SW'(r_running) == SW'(r_created)))
        else $error("task accounting broken");

    a_created_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_created <= CW'(MAX_TASKS))
        else $error("task count beyond table size");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_ctrl.push && !q_ctrl.pop) |-> (q_fill < CW'(MAX_TASKS)))
        else $error("push into full ready queue");

    a_walk_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_we && d_re) |-> (d_waddr != d_raddr))
        else $error("delay memory read and write collide");

    a_start_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted command did not raise busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/rrts_ready_queue.sv =====
// ----------------------------------------------------------------------------
// rrts_ready_queue
// Circular queue of ready task ids in a one-port-read, one-port-write
// memory. A pop and a push may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ready_queue
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire t_q_ctrl                                 i_ctrl,
    input  wire logic [(MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1)-1:0] i_push_id,
    output logic      [(MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1)-1:0] o_pop_id,
    output logic      [$clog2(MAX_TASKS + 1)-1:0]        o_fill
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0] mem [MAX_TASKS];
    logic [IW-1:0] r_rd;
    logic [IW-1:0] r_head;
    logic [IW-1:0] n_head;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [IW-1:0] tail_idx;

    // tail = (head + fill) mod depth, the sum stays below twice the depth
    always_comb begin
        tail_sum  = SW'(r_head) + SW'(r_fill);
        tail_wrap = (tail_sum >= SW'(MAX_TASKS)) ? (tail_sum - SW'(MAX_TASKS)) : tail_sum;
        tail_idx  = tail_wrap[IW-1:0];
    end

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctrl.pop) begin
            n_head = (r_head == IW'(MAX_TASKS - 1)) ? '0 : (r_head + IW'(1));
        end
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_fill = r_fill + CW'(1);
        end else if (!i_ctrl.push && i_ctrl.pop) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[tail_idx] <= i_push_id;
        end
        if (i_ctrl.pop) begin
            r_rd <= mem[r_head];
        end
    end

    assign o_pop_id = r_rd;
    assign o_fill   = r_fill;

endmodule

`default_nettype wire
